FILE: hdl/ghb_pkg.sv
// shared types and constants of the glyph halfword blender
package ghb_pkg;

    // configuration port geometry
    localparam int ADDR_W = 5;

    // register indexes on the configuration port
    localparam logic [2:0] REG_PIXEL_DEPTH  = 3'd0;
    localparam logic [2:0] REG_DRAW_WIDTH   = 3'd1;
    localparam logic [2:0] REG_START_X_ODD  = 3'd2;
    localparam logic [2:0] REG_INK_COLOR    = 3'd3;
    localparam logic [2:0] REG_PALETTE      = 3'd4;
    localparam logic [2:0] REG_USE_PALETTE  = 3'd5;
    localparam logic [2:0] REG_BLEND_ENABLE = 3'd6;

    // pixel depth codes
    localparam logic [1:0] DEPTH_NONE = 2'd0;
    localparam logic [1:0] DEPTH_1BPP = 2'd1;
    localparam logic [1:0] DEPTH_2BPP = 2'd2;
    localparam logic [1:0] DEPTH_8BPP = 2'd3;

    // byte lanes of a framebuffer halfword
    localparam logic [15:0] LO_MASK = 16'h00ff;
    localparam logic [15:0] HI_MASK = 16'hff00;

    // pixel index within the window and its bit position
    localparam int IDX_W = 8;
    localparam int POS_W = 11;

    // configuration register set
    typedef struct packed {
        logic [1:0]  pixel_depth;
        logic [5:0]  draw_width;
        logic        start_x_odd;
        logic [7:0]  ink_color;
        logic [31:0] palette_entries;
        logic        use_glyph_palette;
        logic        blend_enable;
    } cfg_t;

    // slot decode stage to pixel fetch stage
    typedef struct packed {
        logic             write_enable;
        logic             last_slot;
        logic             lo_keep;
        logic             hi_keep;
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
        logic [15:0]      existing_word;
    } s1_t;

    // pixel fetch stage to blend stage
    typedef struct packed {
        logic        write_enable;
        logic        last_slot;
        logic        lo_keep;
        logic        hi_keep;
        logic [7:0]  code_a;
        logic [7:0]  code_b;
        logic [15:0] existing_word;
    } s2_t;

endpackage

FILE: hdl/ghb_cfg_regs.sv
// configuration registers behind the apb-style port
module ghb_cfg_regs
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ghb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output ghb_pkg::cfg_t             cfg
);

    ghb_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_depth       <= ghb_pkg::DEPTH_1BPP;
            cfg_reg.draw_width        <= 6'd8;
            cfg_reg.start_x_odd       <= 1'b0;
            cfg_reg.ink_color         <= 8'hff;
            cfg_reg.palette_entries   <= 32'd0;
            cfg_reg.use_glyph_palette <= 1'b0;
            cfg_reg.blend_enable      <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                ghb_pkg::REG_PIXEL_DEPTH:  cfg_reg.pixel_depth       <= pwdata[1:0];
                ghb_pkg::REG_DRAW_WIDTH:   cfg_reg.draw_width        <= pwdata[5:0];
                ghb_pkg::REG_START_X_ODD:  cfg_reg.start_x_odd       <= pwdata[0];
                ghb_pkg::REG_INK_COLOR:    cfg_reg.ink_color         <= pwdata[7:0];
                ghb_pkg::REG_PALETTE:      cfg_reg.palette_entries   <= pwdata;
                ghb_pkg::REG_USE_PALETTE:  cfg_reg.use_glyph_palette <= pwdata[0];
                ghb_pkg::REG_BLEND_ENABLE: cfg_reg.blend_enable      <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            ghb_pkg::REG_PIXEL_DEPTH:  prdata = {30'd0, cfg_reg.pixel_depth};
            ghb_pkg::REG_DRAW_WIDTH:   prdata = {26'd0, cfg_reg.draw_width};
            ghb_pkg::REG_START_X_ODD:  prdata = {31'd0, cfg_reg.start_x_odd};
            ghb_pkg::REG_INK_COLOR:    prdata = {24'd0, cfg_reg.ink_color};
            ghb_pkg::REG_PALETTE:      prdata = cfg_reg.palette_entries;
            ghb_pkg::REG_USE_PALETTE:  prdata = {31'd0, cfg_reg.use_glyph_palette};
            ghb_pkg::REG_BLEND_ENABLE: prdata = {31'd0, cfg_reg.blend_enable};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

FILE: hdl/ghb_slot_decode.sv
// first stage: slot bounds, byte keep flags and pixel bit positions
module ghb_slot_decode
#(
    parameter int WINDOW_BITS = 64,
    parameter int MAX_WIDTH   = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   valid_in,
    input  logic [WINDOW_BITS-1:0] glyph_window,
    input  logic [5:0]             pixel_offset,
    input  logic [5:0]             slot_index,
    input  logic [15:0]            existing_word,
    input  ghb_pkg::cfg_t          cfg,
    output logic                   valid_out,
    output logic [WINDOW_BITS-1:0] window_out,
    output ghb_pkg::s1_t           s1_out
);

    logic                            valid_reg;
    logic [WINDOW_BITS-1:0]          window_reg;
    ghb_pkg::s1_t                    s1_reg;
    ghb_pkg::s1_t                    s1_next;
    logic [6:0]                      dw7;
    logic [6:0]                      gw;
    logic [6:0]                      slots;
    logic [6:0]                      slot7;
    logic                            xo;
    logic                            first_odd;
    logic                            last;
    logic [ghb_pkg::IDX_W-1:0]       p;
    logic [ghb_pkg::IDX_W-1:0]       idx_a;
    logic [ghb_pkg::IDX_W-1:0]       idx_b;
    logic [ghb_pkg::POS_W-1:0]       wide_a;
    logic [ghb_pkg::POS_W-1:0]       wide_b;

    // row extent and slot position
    always_comb
    begin
        xo        = cfg.start_x_odd;
        dw7       = {1'b0, cfg.draw_width};
        gw        = (dw7 > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : dw7;
        slots     = {1'b0, gw[6:1]} + {6'd0, xo | gw[0]};
        slot7     = {1'b0, slot_index};
        last      = (slot7 + 7'd1) == slots;
        first_odd = (slot_index == 6'd0) && xo;
    end

    // pixel indexes and their bit positions
    always_comb
    begin
        p      = {1'b0, slot_index, 1'b0} - {7'd0, xo};
        idx_a  = {2'd0, pixel_offset} + p;
        idx_b  = first_odd ? {2'd0, pixel_offset} : idx_a + 8'd1;
        wide_a = {3'd0, idx_a};
        wide_b = {3'd0, idx_b};
        case (cfg.pixel_depth)
            ghb_pkg::DEPTH_2BPP:
            begin
                s1_next.pos_a = wide_a << 1;
                s1_next.pos_b = wide_b << 1;
            end
            ghb_pkg::DEPTH_8BPP:
            begin
                s1_next.pos_a = wide_a << 3;
                s1_next.pos_b = wide_b << 3;
            end
            default:
            begin
                s1_next.pos_a = wide_a;
                s1_next.pos_b = wide_b;
            end
        endcase
        s1_next.write_enable  = (cfg.pixel_depth != ghb_pkg::DEPTH_NONE) && (slot7 < slots);
        s1_next.last_slot     = last;
        s1_next.lo_keep       = first_odd;
        s1_next.hi_keep       = !first_odd && last && (xo ^ gw[0]);
        s1_next.existing_word = existing_word;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en && valid_in)
        begin
            s1_reg     <= s1_next;
            window_reg <= glyph_window;
        end
    end

    assign valid_out  = valid_reg;
    assign window_out = window_reg;
    assign s1_out     = s1_reg;

endmodule

FILE: hdl/ghb_pixel_fetch.sv
// second stage: pulls the two pixel codes out of the glyph window
module ghb_pixel_fetch
#(
    parameter int WINDOW_BITS = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   valid_in,
    input  logic [WINDOW_BITS-1:0] window_in,
    input  ghb_pkg::s1_t           s1_in,
    input  ghb_pkg::cfg_t          cfg,
    output logic                   valid_out,
    output ghb_pkg::s2_t           s2_out
);

    localparam int SH_W = $clog2(WINDOW_BITS);

    logic         valid_reg;
    ghb_pkg::s2_t s2_reg;
    ghb_pkg::s2_t s2_next;
    logic [3:0]   bits;
    logic [7:0]   mask;

    // code at a bit position, zero when it runs past the window end
    function automatic logic [7:0] extract
    (
        input logic [WINDOW_BITS-1:0]    win,
        input logic [ghb_pkg::POS_W-1:0] pos,
        input logic [3:0]                nbits,
        input logic [7:0]                nmask
    );
        logic [11:0]            pend;
        logic [11:0]            sh;
        logic [WINDOW_BITS-1:0] shifted;
        logic [7:0]             code;
        pend    = {1'b0, pos} + {8'd0, nbits};
        sh      = 12'(WINDOW_BITS) - pend;
        shifted = win >> sh[SH_W-1:0];
        code    = (pend <= 12'(WINDOW_BITS)) ? (shifted[7:0] & nmask) : 8'd0;
        return code;
    endfunction

    // pixel width and code mask
    always_comb
    begin
        case (cfg.pixel_depth)
            ghb_pkg::DEPTH_8BPP:
            begin
                bits = 4'd8;
                mask = 8'hff;
            end
            ghb_pkg::DEPTH_2BPP:
            begin
                bits = 4'd2;
                mask = 8'h03;
            end
            ghb_pkg::DEPTH_1BPP:
            begin
                bits = 4'd1;
                mask = 8'h01;
            end
            default:
            begin
                bits = 4'd0;
                mask = 8'h00;
            end
        endcase
    end

    // fetch both codes
    always_comb
    begin
        s2_next.write_enable  = s1_in.write_enable;
        s2_next.last_slot     = s1_in.last_slot;
        s2_next.lo_keep       = s1_in.lo_keep;
        s2_next.hi_keep       = s1_in.hi_keep;
        s2_next.code_a        = extract(window_in, s1_in.pos_a, bits, mask);
        s2_next.code_b        = extract(window_in, s1_in.pos_b, bits, mask);
        s2_next.existing_word = s1_in.existing_word;
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en && valid_in)
        begin
            s2_reg <= s2_next;
        end
    end

    assign valid_out = valid_reg;
    assign s2_out    = s2_reg;

endmodule

FILE: hdl/ghb_pixel_blend.sv
// third stage: palette mapping, blending and the output register
module ghb_pixel_blend
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_in,
    input  ghb_pkg::s2_t  s2_in,
    input  ghb_pkg::cfg_t cfg,
    output logic          out_valid,
    output logic [15:0]   out_word,
    output logic          write_enable,
    output logic          last_slot
);

    logic        valid_reg;
    logic [15:0] word_reg;
    logic [15:0] word_next;
    logic        we_reg;
    logic        last_reg;
    logic [15:0] v;
    logic [7:0]  map_a;
    logic [7:0]  map_b;
    logic [7:0]  lo;
    logic [7:0]  hi;

    // code to color through palette or built-in pair
    function automatic logic [7:0] map_code
    (
        input logic [7:0]    code,
        input ghb_pkg::cfg_t c
    );
        logic [7:0] color;
        if (c.pixel_depth == ghb_pkg::DEPTH_8BPP)
        begin
            color = code;
        end
        else if (c.use_glyph_palette)
        begin
            case (code[1:0])
                2'd0:    color = c.palette_entries[7:0];
                2'd1:    color = c.palette_entries[15:8];
                2'd2:    color = c.palette_entries[23:16];
                default: color = c.palette_entries[31:24];
            endcase
        end
        else
        begin
            color = (code == 8'd1) ? c.ink_color : 8'd0;
        end
        return color;
    endfunction

    // blend against the existing halfword
    always_comb
    begin
        v     = cfg.blend_enable ? s2_in.existing_word : 16'd0;
        map_a = map_code(s2_in.code_a, cfg);
        map_b = map_code(s2_in.code_b, cfg);
        lo    = (s2_in.lo_keep || map_a == 8'd0) ? v[7:0] : map_a;
        hi    = (s2_in.hi_keep || map_b == 8'd0) ? v[15:8] : map_b;
        word_next = s2_in.write_enable
                  ? (({8'd0, lo} & ghb_pkg::LO_MASK) | ({hi, 8'd0} & ghb_pkg::HI_MASK))
                  : 16'd0;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (en && valid_in)
        begin
            word_reg <= word_next;
            we_reg   <= s2_in.write_enable;
            last_reg <= s2_in.write_enable && s2_in.last_slot;
        end
    end

    assign out_valid    = valid_reg;
    assign out_word     = word_reg;
    assign write_enable = we_reg;
    assign last_slot    = last_reg;

endmodule

FILE: hdl/glyph_halfword_blender_unit.sv
// top level of the glyph halfword blender
//
// Takes one request per cycle on the input channel (in_valid / in_stall) while
// in_stall is low: a packed glyph row window, the row start offset in pixels, a
// halfword slot number and the framebuffer halfword now at that slot. It returns
// one request per input on the output channel (out_valid / out_stall): the halfword
// to store, a write enable and a last-slot flag. Drawing options sit in registers on
// the apb-style port and must be written by the user only while the block is idle;
// the block itself does not enforce this. A request accepted passes the slot decode,
// pixel fetch and blend registers in that order before it shows on out_valid;
// throughput is one halfword per cycle while out_stall is low.
// Each stage advances when the stage after it is empty or moving, so bubbles close
// up; with out_stall held, the pipeline fills and in_stall rises once all three
// stages hold requests.
// Reset clears all stage valid bits and loads the register defaults: 1 bpp, width 8,
// even start, ink 0xff, built-in palette, blending off.
module glyph_halfword_blender_unit
#(
    parameter int WINDOW_BITS = 64,
    parameter int MAX_WIDTH   = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ghb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [WINDOW_BITS-1:0]     glyph_window,
    input  logic [5:0]                 pixel_offset,
    input  logic [5:0]                 slot_index,
    input  logic [15:0]                existing_word,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [15:0]                out_word,
    output logic                       write_enable,
    output logic                       last_slot
);

    ghb_pkg::cfg_t          cfg;
    ghb_pkg::s1_t           s1;
    ghb_pkg::s2_t           s2;
    logic [WINDOW_BITS-1:0] window_s1;
    logic                   v1;
    logic                   v2;
    logic                   en1;
    logic                   en2;
    logic                   en3;

    // stage advance chain
    assign en3      = !out_valid || !out_stall;
    assign en2      = !v2 || en3;
    assign en1      = !v1 || en2;
    assign in_stall = !en1;

    ghb_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ghb_slot_decode
    #(
        .WINDOW_BITS (WINDOW_BITS),
        .MAX_WIDTH   (MAX_WIDTH)
    )
    u_decode
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en1),
        .valid_in      (in_valid),
        .glyph_window  (glyph_window),
        .pixel_offset  (pixel_offset),
        .slot_index    (slot_index),
        .existing_word (existing_word),
        .cfg           (cfg),
        .valid_out     (v1),
        .window_out    (window_s1),
        .s1_out        (s1)
    );

    ghb_pixel_fetch
    #(
        .WINDOW_BITS (WINDOW_BITS)
    )
    u_fetch
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en2),
        .valid_in  (v1),
        .window_in (window_s1),
        .s1_in     (s1),
        .cfg       (cfg),
        .valid_out (v2),
        .s2_out    (s2)
    );

    ghb_pixel_blend u_blend
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en3),
        .valid_in     (v2),
        .s2_in        (s2),
        .cfg          (cfg),
        .out_valid    (out_valid),
        .out_word     (out_word),
        .write_enable (write_enable),
        .last_slot    (last_slot)
    );

    // input stalls only with every stage full and the output held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1 && v2 && out_valid && out_stall))
        else $error("input stalled with room in the pipeline");

    // last slot only on a written slot
    a_last_we: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_slot) |-> write_enable)
        else $error("last slot flagged on an unwritten slot");

    // unwritten slots carry a zero halfword
    a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable) |-> (out_word == 16'd0))
        else $error("unwritten slot carries data");

    // depth none never writes
    a_depth_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && write_enable) |-> (cfg.pixel_depth != ghb_pkg::DEPTH_NONE))
        else $error("write issued with drawing off");

endmodule

FILE: tb/sv/glyph_halfword_blender_unit_tb.sv
// testbench for the glyph halfword blender: directed table and random requests
`timescale 1ns / 1ps

module glyph_halfword_blender_unit_tb;

    localparam int WIN_BITS       = 64;
    localparam int MAX_W          = 32;
    localparam int PIPE_DEPTH     = 3;
    localparam int RANDOM_PHASES  = 12;
    localparam int REQS_PER_PHASE = 84;
    localparam int IDLE_LIMIT     = 2000;

    // expected halfword result
    typedef struct packed {
        logic [15:0] word;
        logic        we;
        logic        last;
    } halfword_t;

    // one row of the directed table
    typedef struct {
        ghb_pkg::cfg_t settings;
        logic [63:0]   window;
        logic [5:0]    offset;
        logic [5:0]    slot;
        logic [15:0]   existing;
        bit            typed;
        halfword_t     want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ghb_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] glyph_window = '0;
    logic [5:0]  pixel_offset = '0;
    logic [5:0]  slot_index = '0;
    logic [15:0] existing_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] out_word;
    logic        write_enable;
    logic        last_slot;

    // expectation attached to the request on the wire
    bit          row_typed = 1'b0;
    halfword_t   row_want = '0;

    ghb_pkg::cfg_t active_cfg;
    halfword_t     expected_halfwords[$];
    stim_row_t     dir_rows[$];

    int mismatches = 0;
    int requests_accepted = 0;
    int results_seen = 0;
    int writes_seen = 0;
    int last_slots_seen = 0;
    int settings_loaded = 0;
    int idle_cycles = 0;
    int burst_left = 1;
    int stall_left = 0;
    bit sending = 1'b0;

    glyph_halfword_blender_unit dut (.*);

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic ghb_pkg::cfg_t mk_cfg(logic [1:0] depth, logic [5:0] width,
                                             logic xodd, logic [7:0] ink, logic [31:0] pal,
                                             logic usep, logic blend);
        ghb_pkg::cfg_t c;
        c.pixel_depth       = depth;
        c.draw_width        = width;
        c.start_x_odd       = xodd;
        c.ink_color         = ink;
        c.palette_entries   = pal;
        c.use_glyph_palette = usep;
        c.blend_enable      = blend;
        return c;
    endfunction

    function automatic int unsigned slot_count(ghb_pkg::cfg_t c);
        int unsigned gw;
        gw = (c.draw_width > MAX_W) ? MAX_W : c.draw_width;
        return gw / 2 + (c.start_x_odd | (gw & 1));
    endfunction

    // row pixel idx after palette mapping; bits past the window read as code 0
    function automatic logic [7:0] glyph_pixel(ghb_pkg::cfg_t c, logic [63:0] win,
                                               int unsigned off, int unsigned idx);
        int unsigned bits;
        int unsigned pos;
        logic [7:0]  code;
        bits = (c.pixel_depth == ghb_pkg::DEPTH_8BPP) ? 8 : c.pixel_depth;
        pos  = (off + idx) * bits;
        code = '0;
        if (pos + bits <= WIN_BITS)
            code = 8'((win >> (WIN_BITS - pos - bits)) & ((64'd1 << bits) - 64'd1));
        if (c.pixel_depth == ghb_pkg::DEPTH_8BPP)
            return code;
        if (c.use_glyph_palette)
            return c.palette_entries[code[1:0]*8 +: 8];
        return (code == 8'd1) ? c.ink_color : 8'd0;
    endfunction

    // expected halfword for one slot
    function automatic halfword_t blend_halfword(ghb_pkg::cfg_t c, logic [63:0] win,
                                                 logic [5:0] off, logic [5:0] slot,
                                                 logic [15:0] ex);
        halfword_t   r;
        int unsigned gw;
        int unsigned nslots;
        int unsigned p;
        bit          short_end;
        logic [15:0] keep;
        logic [7:0]  lo;
        logic [7:0]  hi;
        r = '0;
        gw = (c.draw_width > MAX_W) ? MAX_W : c.draw_width;
        nslots = slot_count(c);
        short_end = c.start_x_odd ^ gw[0];
        keep = c.blend_enable ? ex : 16'h0000;
        if (c.pixel_depth == ghb_pkg::DEPTH_NONE || slot >= nslots)
            return r;
        if (slot == 0 && c.start_x_odd)
        begin
            // odd start: row pixel 0 goes to the high byte
            lo = keep[7:0];
            hi = glyph_pixel(c, win, off, 0);
            if (hi == 8'd0)
                hi = keep[15:8];
        end
        else
        begin
            p = c.start_x_odd ? 2 * slot - 1 : 2 * slot;
            lo = glyph_pixel(c, win, off, p);
            if (lo == 8'd0)
                lo = keep[7:0];
            if (slot == nslots - 1 && short_end)
                hi = keep[15:8];
            else
            begin
                hi = glyph_pixel(c, win, off, p + 1);
                if (hi == 8'd0)
                    hi = keep[15:8];
            end
        end
        r.word = {hi, lo};
        r.we   = 1'b1;
        r.last = (slot == nslots - 1);
        return r;
    endfunction

    function automatic ghb_pkg::cfg_t random_settings(int ph);
        ghb_pkg::cfg_t c;
        int unsigned   w;
        case ($urandom_range(0, 7))
            0: w = 0;
            1: w = 1;
            2: w = 31;
            3: w = 32;
            4: w = $urandom_range(33, 63);
            default: w = $urandom_range(2, 30);
        endcase
        c.pixel_depth       = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
        c.draw_width        = 6'(w);
        c.start_x_odd       = 1'($urandom_range(0, 1));
        c.ink_color         = 8'($urandom_range(0, 255));
        c.palette_entries   = $urandom;
        c.use_glyph_palette = 1'($urandom_range(0, 1));
        c.blend_enable      = 1'($urandom_range(0, 1));
        // zero palette entries make blending visible
        for (int b = 0; b < 4; b++)
            if ($urandom_range(0, 3) == 0)
                c.palette_entries[b*8 +: 8] = 8'h00;
        if (ph == 4)
            c = mk_cfg(ghb_pkg::DEPTH_8BPP, 6'd63, 1'b1, 8'hff, 32'hffff_ffff, 1'b1, 1'b1);
        else if (ph == 5)
            c = mk_cfg(ghb_pkg::DEPTH_1BPP, 6'd0, 1'b0, 8'h00, 32'h0000_0000, 1'b0, 1'b0);
        return c;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch on %s at result %0d: got %0h, want %0h",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_settings(ghb_pkg::cfg_t c);
        apb_write(ghb_pkg::REG_PIXEL_DEPTH,  32'(c.pixel_depth));
        apb_write(ghb_pkg::REG_DRAW_WIDTH,   32'(c.draw_width));
        apb_write(ghb_pkg::REG_START_X_ODD,  32'(c.start_x_odd));
        apb_write(ghb_pkg::REG_INK_COLOR,    32'(c.ink_color));
        apb_write(ghb_pkg::REG_PALETTE,      c.palette_entries);
        apb_write(ghb_pkg::REG_USE_PALETTE,  32'(c.use_glyph_palette));
        apb_write(ghb_pkg::REG_BLEND_ENABLE, 32'(c.blend_enable));
        active_cfg = c;
        settings_loaded++;
    endtask

    // stop sending and let the pipeline empty out
    task automatic drain();
        if (sending)
        begin
            in_valid <= 1'b0;
            sending = 1'b0;
        end
        @(posedge clk);
        while (expected_halfwords.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // drive one request and hold it until accepted, then maybe open a gap
    task automatic issue_request(logic [63:0] win, logic [5:0] off, logic [5:0] slot,
                                 logic [15:0] ex, bit typed, halfword_t want);
        int gap;
        in_valid      <= 1'b1;
        glyph_window  <= win;
        pixel_offset  <= off;
        slot_index    <= slot;
        existing_word <= ex;
        row_typed     <= typed;
        row_want      <= want;
        sending = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                sending = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic add_row(ghb_pkg::cfg_t c, logic [63:0] win, logic [5:0] off,
                           logic [5:0] slot, logic [15:0] ex, bit typed,
                           logic [15:0] word, bit we, bit last);
        stim_row_t r;
        r.settings = c;
        r.window   = win;
        r.offset   = off;
        r.slot     = slot;
        r.existing = ex;
        r.typed    = typed;
        r.want     = '{word: word, we: we, last: last};
        dir_rows.push_back(r);
    endtask

    // receiver stall pattern: short stalls, short flows and long free stretches
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    out_stall <= 1'b1;
                    stall_left = $urandom_range(0, 7);
                end
                3:
                begin
                    out_stall <= 1'b0;
                    stall_left = $urandom_range(50, 200);
                end
                default:
                begin
                    out_stall <= 1'b0;
                    stall_left = $urandom_range(0, 12);
                end
            endcase
        end
    end

    // result checking and request prediction
    always @(posedge clk)
    begin
        halfword_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_halfwords.size() == 0)
                    report_mismatch("unexpected out_word", out_word, 0);
                else
                begin
                    want = expected_halfwords.pop_front();
                    if (out_word !== want.word)
                        report_mismatch("out_word", out_word, want.word);
                    if (write_enable !== want.we)
                        report_mismatch("write_enable", write_enable, want.we);
                    if (last_slot !== want.last)
                        report_mismatch("last_slot", last_slot, want.last);
                end
                results_seen++;
                if (write_enable)
                    writes_seen++;
                if (last_slot)
                    last_slots_seen++;
            end
            if (in_valid && !in_stall)
            begin
                expected_halfwords.push_back(row_typed ? row_want :
                    blend_halfword(active_cfg, glyph_window, pixel_offset, slot_index,
                                   existing_word));
                requests_accepted++;
            end
        end
    end

    // watchdog on cycles with no progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d cycles without progress", idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        ghb_pkg::cfg_t c_rst;
        ghb_pkg::cfg_t c;
        logic [63:0]   win;
        logic [5:0]    off;
        logic [5:0]    slot;
        logic [15:0]   ex;
        int unsigned   nslots;

        c_rst = mk_cfg(ghb_pkg::DEPTH_1BPP, 6'd8, 1'b0, 8'hff, 32'h0, 1'b0, 1'b0);
        active_cfg = c_rst;

        // reset defaults, slot range and depth zero
        add_row(c_rst, 64'h0, 6'd0, 6'd0, 16'hffff, 1, 16'h0000, 1, 0);
        add_row(c_rst, '1, 6'd0, 6'd0, 16'h0000, 1, 16'hffff, 1, 0);
        add_row(c_rst, '1, 6'd5, 6'd3, 16'h1234, 1, 16'hffff, 1, 1);
        add_row(c_rst, '1, 6'd0, 6'd4, 16'h1234, 1, 16'h0000, 0, 0);
        add_row(c_rst, '1, 6'd0, 6'd63, 16'hffff, 1, 16'h0000, 0, 0);
        add_row(c_rst, 64'ha5a5_5a5a_0f0f_f0f1, 6'd63, 6'd0, 16'h0000, 0, 0, 0, 0);
        add_row(mk_cfg(ghb_pkg::DEPTH_NONE, 6'd8, 1'b0, 8'hff, 32'h0, 1'b0, 1'b0),
                '1, 6'd0, 6'd0, 16'hffff, 1, 16'h0000, 0, 0);
        // two bpp, built-in pair drops codes 2 and 3
        c = mk_cfg(ghb_pkg::DEPTH_2BPP, 6'd8, 1'b0, 8'h5a, 32'h0, 1'b0, 1'b0);
        add_row(c, 64'h1b1b_1b1b_1b1b_1b1b, 6'd0, 6'd0, 16'h0000, 0, 0, 0, 0);
        add_row(c, 64'h1b1b_1b1b_1b1b_1b1b, 6'd0, 6'd1, 16'h0000, 0, 0, 0, 0);
        c = mk_cfg(ghb_pkg::DEPTH_2BPP, 6'd8, 1'b0, 8'h5a, 32'h4433_2211, 1'b1, 1'b0);
        add_row(c, 64'h1b1b_1b1b_1b1b_1b1b, 6'd0, 6'd0, 16'h0000, 0, 0, 0, 0);
        add_row(c, 64'h1b1b_1b1b_1b1b_1b1b, 6'd1, 6'd1, 16'h0000, 0, 0, 0, 0);
        // eight bpp, including a pixel past the window end
        c = mk_cfg(ghb_pkg::DEPTH_8BPP, 6'd8, 1'b0, 8'hff, 32'h0, 1'b0, 1'b0);
        add_row(c, 64'h0123_4567_89ab_cdef, 6'd0, 6'd0, 16'hffff, 0, 0, 0, 0);
        add_row(c, 64'h0123_4567_89ab_cdef, 6'd0, 6'd3, 16'hffff, 0, 0, 0, 0);
        add_row(c, 64'h0123_4567_89ab_cdef, 6'd7, 6'd0, 16'hffff, 0, 0, 0, 0);
        add_row(mk_cfg(ghb_pkg::DEPTH_8BPP, 6'd8, 1'b0, 8'hff, 32'h0, 1'b0, 1'b1),
                64'h00ff_0011_2200_0000, 6'd0, 6'd1, 16'ha55a, 0, 0, 0, 0);
        // odd start with zero width writes one slot
        c = mk_cfg(ghb_pkg::DEPTH_1BPP, 6'd0, 1'b1, 8'hff, 32'h0, 1'b0, 1'b1);
        add_row(c, '1, 6'd0, 6'd0, 16'hbeef, 0, 0, 0, 0);
        add_row(c, '1, 6'd0, 6'd1, 16'hbeef, 1, 16'h0000, 0, 0);
        // odd widths at first and last slots
        c = mk_cfg(ghb_pkg::DEPTH_1BPP, 6'd7, 1'b1, 8'hff, 32'h00a0_b0c0, 1'b1, 1'b0);
        add_row(c, 64'h5500_0000_0000_0000, 6'd0, 6'd0, 16'h7777, 0, 0, 0, 0);
        add_row(c, 64'h5500_0000_0000_0000, 6'd0, 6'd3, 16'h7777, 0, 0, 0, 0);
        add_row(mk_cfg(ghb_pkg::DEPTH_1BPP, 6'd7, 1'b0, 8'h3c, 32'h0, 1'b0, 1'b1),
                '1, 6'd0, 6'd3, 16'h9876, 0, 0, 0, 0);
        // width above the maximum is clamped
        c = mk_cfg(ghb_pkg::DEPTH_1BPP, 6'd63, 1'b0, 8'hff, 32'h0, 1'b0, 1'b0);
        add_row(c, '1, 6'd0, 6'd15, 16'h0000, 1, 16'hffff, 1, 1);
        add_row(c, '1, 6'd0, 6'd16, 16'h0000, 1, 16'h0000, 0, 0);
        // zero ink blends into the existing halfword
        add_row(mk_cfg(ghb_pkg::DEPTH_1BPP, 6'd8, 1'b0, 8'h00, 32'h0, 1'b0, 1'b1),
                '1, 6'd0, 6'd0, 16'h1357, 0, 0, 0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[k])
        begin
            if (dir_rows[k].settings != active_cfg)
            begin
                drain();
                load_settings(dir_rows[k].settings);
            end
            issue_request(dir_rows[k].window, dir_rows[k].offset, dir_rows[k].slot,
                          dir_rows[k].existing, dir_rows[k].typed, dir_rows[k].want);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            load_settings(random_settings(ph));
            nslots = slot_count(active_cfg);
            for (int n = 0; n < REQS_PER_PHASE; n++)
            begin
                case ($urandom_range(0, 3))
                    0: win = {$urandom, $urandom} & {$urandom, $urandom};
                    1: win = {$urandom, $urandom} | {$urandom, $urandom};
                    2: win = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
                    default: win = {$urandom, $urandom};
                endcase
                off = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7))
                                                  : 6'($urandom_range(0, 63));
                slot = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, nslots))
                                                  : 6'($urandom_range(0, 63));
                case ($urandom_range(0, 7))
                    0: ex = 16'h0000;
                    1: ex = 16'hffff;
                    default: ex = 16'($urandom);
                endcase
                issue_request(win, off, slot, ex, 1'b0, '0);
            end
        end
        drain();

        $display("%0d requests under %0d register settings, %0d results checked",
                 requests_accepted, settings_loaded, results_seen);
        $display("%0d halfword writes, %0d row ends, %0d mismatches",
                 writes_seen, last_slots_seen, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
